[src/remote_ip_private_classifier_defines.svh]
// Assertion macros shared by the classifier RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef REMOTE_IP_PRIVATE_CLASSIFIER_DEFINES_SVH
`define REMOTE_IP_PRIVATE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rip_pkg.sv]
// Types and character constants for the private peer address classifier.
// Used by rip_step and by the top level remote_ip_private_classifier.
package rip_pkg;

    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_ONE      = 8'h31;
    localparam logic [7:0] CH_EIGHT    = 8'h38;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_B  = 8'h62;
    localparam logic [7:0] CH_LOWER_C  = 8'h63;
    localparam logic [7:0] CH_LOWER_D  = 8'h64;
    localparam logic [7:0] CH_LOWER_E  = 8'h65;
    localparam logic [7:0] CH_LOWER_F  = 8'h66;

    localparam logic [7:0]  CASE_OFFSET  = 8'd32;
    localparam logic [8:0]  OCTET_MAX    = 9'd255;
    localparam logic [11:0] OCTET_SAT    = 12'd256;
    localparam logic [2:0]  OCTET_COUNT  = 3'd4;
    localparam logic [7:0]  NET_LOOPBACK = 8'd127;
    localparam logic [7:0]  NET_TEN      = 8'd10;
    localparam logic [15:0] MASK_172     = 16'hFFF0;
    localparam logic [15:0] NET_172_16   = 16'hAC10;
    localparam logic [15:0] NET_192_168  = 16'hC0A8;
    localparam logic [15:0] NET_169_254  = 16'hA9FE;

    typedef struct packed {
        logic        in_text;
        logic        opened_bracket;
        logic [1:0]  char_count;
        logic [23:0] lowered_prefix;
        logic        overlong;
        logic        outer_prefix_private;
        logic [8:0]  octet_value;
        logic [1:0]  octet_digits;
        logic        first_digit_zero;
        logic [2:0]  octets_done;
        logic [31:0] address_acc;
        logic        ipv4_failed;
    } rip_state_t;

    typedef struct packed {
        logic        is_private;
        logic        was_ipv4;
        logic [31:0] ipv4_value;
    } rip_result_t;

    localparam rip_state_t STATE_CLEAR = '0;

endpackage

[src/rip_step.sv]
// Per-character update of the classifier state and the verdict on the last character.
// Purely combinational; depends on rip_pkg.
module rip_step
    import rip_pkg::*;
(
    input  rip_state_t  state_cur,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    input  logic        no_char,
    output rip_state_t  state_next,
    output logic        produce,
    output rip_result_t result
);

    function automatic rip_state_t close_octet(input rip_state_t s);
        rip_state_t r;
        r = s;
        if (s.octet_digits == 2'd0 || s.octet_value > OCTET_MAX) begin
            r.ipv4_failed = 1'b1;
        end else begin
            r.address_acc = {s.address_acc[23:0], s.octet_value[7:0]};
            if (s.octets_done < 3'd7) begin
                r.octets_done = s.octets_done + 3'd1;
            end
        end
        r.octet_value      = '0;
        r.octet_digits     = '0;
        r.first_digit_zero = 1'b0;
        return r;
    endfunction

    function automatic rip_state_t feed(input rip_state_t s, input logic [7:0] c);
        rip_state_t  r;
        logic [7:0]  lc;
        logic [3:0]  d;
        logic [11:0] v;
        r  = s;
        lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
        d  = 4'(c - CH_ZERO);
        v  = '0;
        unique case (s.char_count)
            2'd0: begin
                r.lowered_prefix[7:0] = lc;
                r.char_count = 2'd1;
            end
            2'd1: begin
                r.lowered_prefix[15:8] = lc;
                r.char_count = 2'd2;
                if (s.lowered_prefix[7:0] == CH_LOWER_F &&
                    (lc == CH_LOWER_C || lc == CH_LOWER_D)) begin
                    r.outer_prefix_private = 1'b1;
                end
            end
            2'd2: begin
                r.lowered_prefix[23:16] = lc;
                r.char_count = 2'd3;
                if (s.lowered_prefix[7:0] == CH_LOWER_F &&
                    s.lowered_prefix[15:8] == CH_LOWER_E &&
                    (lc == CH_EIGHT || lc == CH_NINE ||
                     lc == CH_LOWER_A || lc == CH_LOWER_B)) begin
                    r.outer_prefix_private = 1'b1;
                end
            end
            default: begin
                r.overlong = 1'b1;
            end
        endcase

        if (!s.ipv4_failed) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                if (s.octet_digits == 2'd0) begin
                    r.first_digit_zero = (d == 4'd0);
                    r.octet_value      = {5'd0, d};
                    r.octet_digits     = 2'd1;
                end else if (s.first_digit_zero && d > 4'd7) begin
                    // An octal octet may not hold an eight or a nine.
                    r.ipv4_failed = 1'b1;
                end else begin
                    if (s.first_digit_zero) begin
                        v = {3'd0, s.octet_value} * 12'd8 + {8'd0, d};
                    end else begin
                        v = {3'd0, s.octet_value} * 12'd10 + {8'd0, d};
                    end
                    r.octet_value  = (v > OCTET_SAT) ? OCTET_SAT[8:0] : v[8:0];
                    r.octet_digits = 2'd2;
                end
            end else if (c == CH_DOT) begin
                r = close_octet(r);
                if (r.octets_done >= OCTET_COUNT) begin
                    r.ipv4_failed = 1'b1;
                end
            end else begin
                r.ipv4_failed = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic rip_result_t finalize(input rip_state_t s);
        rip_state_t  f;
        rip_result_t r;
        logic        loop6;
        f = s;
        r = '0;
        if (!f.ipv4_failed) begin
            f = close_octet(f);
        end
        if (!f.ipv4_failed && f.octets_done == OCTET_COUNT) begin
            r.was_ipv4   = 1'b1;
            r.ipv4_value = f.address_acc;
            r.is_private = (f.address_acc[31:24] == NET_LOOPBACK) ||
                           (f.address_acc[31:24] == NET_TEN) ||
                           ((f.address_acc[31:16] & MASK_172) == NET_172_16) ||
                           (f.address_acc[31:16] == NET_192_168) ||
                           (f.address_acc[31:16] == NET_169_254) ||
                           (f.address_acc == 32'd0);
        end else begin
            loop6 = (f.char_count == 2'd3) && !f.overlong &&
                    (f.lowered_prefix[7:0] == CH_COLON) &&
                    (f.lowered_prefix[15:8] == CH_COLON) &&
                    (f.lowered_prefix[23:16] == CH_ONE);
            r.is_private = loop6 || f.outer_prefix_private;
        end
        return r;
    endfunction

    rip_state_t fed;

    assign fed = feed(state_cur, char_code);

    always_comb begin
        state_next = state_cur;
        produce    = 1'b0;
        result     = '0;
        priority if (no_char) begin
            produce    = 1'b1;
            state_next = STATE_CLEAR;
        end else if (!state_cur.in_text && char_code == CH_LBRACKET && !last_char) begin
            state_next.in_text        = 1'b1;
            state_next.opened_bracket = 1'b1;
        end else if (state_cur.in_text && state_cur.opened_bracket && last_char) begin
            // The closing bracket is stripped, so the text ends before it.
            produce    = 1'b1;
            state_next = STATE_CLEAR;
            if (char_code == CH_RBRACKET) begin
                result = finalize(state_cur);
            end
        end else begin
            if (last_char) begin
                produce    = 1'b1;
                result     = finalize(fed);
                state_next = STATE_CLEAR;
            end else begin
                state_next         = fed;
                state_next.in_text = 1'b1;
            end
        end
    end

endmodule

[src/remote_ip_private_classifier.sv]
// Top level of the private peer address classifier: input register, state and result register.
// Depends on rip_pkg, rip_step and remote_ip_private_classifier_defines.svh.
//
// The address text enters one character per transaction, the final character marked by
// s_tlast; s_tuser set stands for an empty string and ends the text. One verdict leaves on
// m_* for each text, registered in the result register when its last character leaves the
// input register, and characters that end nothing give no transaction. One character is
// taken every cycle unless a verdict waits on a stalled m_*; the state update for a character
// is a single pass through rip_step between the input and result registers, and the next
// character needs only that state. During that stall the character waits in the input register and s_tready drops.
`include "remote_ip_private_classifier_defines.svh"

module remote_ip_private_classifier
    import rip_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last_char
    input  logic        s_tuser,   // no_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [0] is_private, [32:1] ipv4_value, [39:33] zero
    output logic        m_tuser    // was_ipv4
);

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    logic        in_none_reg;
    rip_state_t  state_reg;
    rip_state_t  state_next;
    rip_state_t  state_cur_sel;
    logic        produce;
    rip_result_t result;
    logic        out_valid_reg;
    rip_result_t out_reg;
    logic        advance;

    // The held character moves on once the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign state_cur_sel = state_reg;

    rip_step u_step (
        .state_cur  (state_cur_sel),
        .char_code  (in_char_reg),
        .last_char  (in_last_reg),
        .no_char    (in_none_reg),
        .state_next (state_next),
        .produce    (produce),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_CLEAR;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance && produce) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
            in_none_reg <= s_tuser;
        end
        if (advance && produce) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.ipv4_value, out_reg.is_private};
    assign m_tuser  = out_reg.was_ipv4;

    `RIP_ASSERT_NOW(a_value_zero_unless_ipv4, aclk, aresetn, out_valid_reg && !out_reg.was_ipv4, out_reg.ipv4_value == 32'd0, "address value not zero on a non-IPv4 verdict")
    `RIP_ASSERT_NEXT(a_held_char_kept, aclk, aresetn, in_valid_reg && out_valid_reg && !m_tready, in_valid_reg, "held character lost while the output stalled")
    `RIP_ASSERT_NEXT(a_state_cleared, aclk, aresetn, advance && produce, !state_reg.in_text && state_reg.address_acc == 32'd0, "state not cleared after a verdict")
    `RIP_ASSERT_NOW(a_octets_bounded, aclk, aresetn, 1'b1, state_reg.octets_done <= OCTET_COUNT, "octet count beyond four")

endmodule
